// ----- sv/yuyv2rgb_pkg.sv -----
package yuyv2rgb_pkg;

   localparam int ByteWidth = 8;
   localparam int SumWidth  = 20;

   localparam logic signed [SumWidth-1:0] CoefRv       = 20'sd359;
   localparam logic signed [SumWidth-1:0] CoefGu       = 20'sd88;
   localparam logic signed [SumWidth-1:0] CoefGv       = 20'sd183;
   localparam logic signed [SumWidth-1:0] CoefBu       = 20'sd454;
   localparam logic signed [SumWidth-1:0] ChromaOffset = 20'sd128;
   localparam logic signed [SumWidth-1:0] ChannelMax   = 20'sd255;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 group_start;
   } req_item_type;

   typedef struct packed {
      logic [ByteWidth-1:0] red;
      logic [ByteWidth-1:0] green;
      logic [ByteWidth-1:0] blue;
      logic                 pair_last;
   } rsp_item_type;

   // One pixel worth of operands handed from the byte assembler to the color math.
   typedef struct packed {
      logic [ByteWidth-1:0] luma;
      logic [ByteWidth-1:0] chroma_u;
      logic [ByteWidth-1:0] chroma_v;
      logic                 pair_last;
   } pix_src_type;

   typedef enum logic [3:0] {
      PH_Y0 = 4'b0001,
      PH_U  = 4'b0010,
      PH_Y1 = 4'b0100,
      PH_V  = 4'b1000
   } phase_type;

   // floor(sum / 256) clamped to 0..255
   function automatic logic [ByteWidth-1:0] shift_clamp(input logic signed [SumWidth-1:0] sum);
      logic signed [SumWidth-1:0] shifted;
      logic [ByteWidth-1:0]       result;
      shifted = sum >>> 8;
      if (shifted < 0) begin
         result = '0;
      end else if (shifted > ChannelMax) begin
         result = '1;
      end else begin
         result = shifted[ByteWidth-1:0];
      end
      return result;
   endfunction

endpackage

// ----- sv/yuyv2rgb_assembler.sv -----
module yuyv2rgb_assembler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  yuyv2rgb_pkg::req_item_type req_data,
   input  logic                       pix_take,
   output logic                       pix_valid,
   output yuyv2rgb_pkg::pix_src_type  pix_src
);
   import yuyv2rgb_pkg::*;

   phase_type            phase_ff, phase_in, phase_eff;
   logic [ByteWidth-1:0] y0_ff, y0_in;
   logic [ByteWidth-1:0] u_ff, u_in;
   logic [ByteWidth-1:0] y1_ff, y1_in;

   // completed group waiting to be split into two pixels
   logic                 grp_valid_ff, grp_valid_in;
   logic                 grp_idx_ff, grp_idx_in;
   logic [ByteWidth-1:0] grp_y0_ff, grp_y0_in;
   logic [ByteWidth-1:0] grp_y1_ff, grp_y1_in;
   logic [ByteWidth-1:0] grp_u_ff, grp_u_in;
   logic [ByteWidth-1:0] grp_v_ff, grp_v_in;

   logic grp_free;
   logic accept;

   assign grp_free  = !grp_valid_ff || (grp_idx_ff && pix_take);
   assign req_stall = (phase_ff == PH_V) && !grp_free;
   assign accept    = req_valid && !req_stall;
   assign phase_eff = req_data.group_start ? PH_Y0 : phase_ff;

   always_comb begin
      phase_in     = phase_ff;
      y0_in        = y0_ff;
      u_in         = u_ff;
      y1_in        = y1_ff;
      grp_valid_in = grp_valid_ff;
      grp_idx_in   = grp_idx_ff;
      grp_y0_in    = grp_y0_ff;
      grp_y1_in    = grp_y1_ff;
      grp_u_in     = grp_u_ff;
      grp_v_in     = grp_v_ff;

      if (pix_take) begin
         if (grp_idx_ff) begin
            grp_valid_in = 1'b0;
         end else begin
            grp_idx_in = 1'b1;
         end
      end

      if (accept) begin
         case (phase_eff)
            PH_Y0: begin
               y0_in    = req_data.data_byte;
               phase_in = PH_U;
            end
            PH_U: begin
               u_in     = req_data.data_byte;
               phase_in = PH_Y1;
            end
            PH_Y1: begin
               y1_in    = req_data.data_byte;
               phase_in = PH_V;
            end
            PH_V: begin
               grp_valid_in = 1'b1;
               grp_idx_in   = 1'b0;
               grp_y0_in    = y0_ff;
               grp_y1_in    = y1_ff;
               grp_u_in     = u_ff;
               grp_v_in     = req_data.data_byte;
               phase_in     = PH_Y0;
            end
            default: begin
               phase_in = PH_Y0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_Y0;
         y0_ff        <= '0;
         u_ff         <= '0;
         y1_ff        <= '0;
         grp_valid_ff <= 1'b0;
         grp_idx_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         y0_ff        <= y0_in;
         u_ff         <= u_in;
         y1_ff        <= y1_in;
         grp_valid_ff <= grp_valid_in;
         grp_idx_ff   <= grp_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_y0_ff <= grp_y0_in;
      grp_y1_ff <= grp_y1_in;
      grp_u_ff  <= grp_u_in;
      grp_v_ff  <= grp_v_in;
   end

   assign pix_valid          = grp_valid_ff;
   assign pix_src.luma       = grp_idx_ff ? grp_y1_ff : grp_y0_ff;
   assign pix_src.chroma_u   = grp_u_ff;
   assign pix_src.chroma_v   = grp_v_ff;
   assign pix_src.pair_last  = grp_idx_ff;

endmodule

// ----- sv/yuyv2rgb_color.sv -----
module yuyv2rgb_color (
   input  yuyv2rgb_pkg::pix_src_type  pix_src,
   output yuyv2rgb_pkg::rsp_item_type pixel
);
   import yuyv2rgb_pkg::*;

   logic signed [SumWidth-1:0] y_s, u_s, v_s;
   logic signed [SumWidth-1:0] r_sum, g_sum, b_sum;

   always_comb begin
      y_s   = $signed({{(SumWidth-ByteWidth-8){1'b0}}, pix_src.luma, 8'b0});
      u_s   = $signed({{(SumWidth-ByteWidth){1'b0}}, pix_src.chroma_u}) - ChromaOffset;
      v_s   = $signed({{(SumWidth-ByteWidth){1'b0}}, pix_src.chroma_v}) - ChromaOffset;
      r_sum = y_s + CoefRv * v_s;
      g_sum = y_s - CoefGu * u_s - CoefGv * v_s;
      b_sum = y_s + CoefBu * u_s;
      pixel.red       = shift_clamp(r_sum);
      pixel.green     = shift_clamp(g_sum);
      pixel.blue      = shift_clamp(b_sum);
      pixel.pair_last = pix_src.pair_last;
   end

endmodule

// ----- sv/yuyv_to_rgb_converter_core.sv -----
// YUYV 4:2:2 to RGB888 converter. Takes one byte of a packed Y0,U,Y1,V stream per
// clock; group_start forces a byte to be taken as Y0 and drops any partial group.
// Each complete group yields two pixels (Y0 pixel first, pair_last marks the Y1
// pixel) on the result channel, one per clock while rsp_stall is low, from a
// result register that follows the color math; an accepted V byte completes the
// pair in the group register, from which each pixel enters the result register.
// A full group register holds the pair while it drains, so with no result stall
// the input never stalls and one byte per clock is sustained. req_stall rises only
// while the V byte is due and the previous pair has not drained, offered or not.
module yuyv_to_rgb_converter_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  yuyv2rgb_pkg::req_item_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output yuyv2rgb_pkg::rsp_item_type rsp_data
);
   import yuyv2rgb_pkg::*;

   logic         pix_valid;
   logic         pix_take;
   pix_src_type  pix_src;
   rsp_item_type pixel;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   yuyv2rgb_assembler u_assembler (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pix_take  (pix_take),
      .pix_valid (pix_valid),
      .pix_src   (pix_src)
   );

   yuyv2rgb_color u_color (
      .pix_src (pix_src),
      .pixel   (pixel)
   );

   assign pix_take     = pix_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pix_take || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = pix_take ? pixel : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the input only waits on a pending pair
   a_stall_needs_pair: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> pix_valid)
      else $error("input stalled with no pair pending");

   // after the first pixel of a pair leaves, the second is next
   a_pair_second: assert property (@(posedge clock) disable iff (reset)
      pix_take && !pix_src.pair_last |=> pix_valid && pix_src.pair_last)
      else $error("second pixel of pair lost");

   // a loaded result register carries what the color math gave
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      pix_take |=> rsp_valid && (rsp_data == $past(pixel)))
      else $error("result register not loaded");

endmodule

// ----- tb/rgb_pair_compare.sv -----
module rgb_pair_compare
   import yuyv2rgb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_data,
   output int           mismatch_count,
   output int           pending_count
);

   localparam int RedFromV   = 359;
   localparam int GreenFromU = 88;
   localparam int GreenFromV = 183;
   localparam int BlueFromU  = 454;
   localparam int ChromaBias = 128;
   localparam int ChannelTop = 255;

   phase_type    byte_phase;
   logic [7:0]   luma_first;
   logic [7:0]   chroma_blue;
   logic [7:0]   luma_second;
   rsp_item_type expected_pixels[$];

   // floor(sum / 256), then clamp to 0..255
   function automatic logic [7:0] clamp_channel(int sum);
      int         scaled;
      logic [7:0] level;
      scaled = sum >>> 8;
      if (scaled < 0) begin
         level = 8'd0;
      end else if (scaled > ChannelTop) begin
         level = 8'd255;
      end else begin
         level = scaled[7:0];
      end
      return level;
   endfunction

   function automatic rsp_item_type convert_pixel(logic [7:0] luma, logic [7:0] cb,
                                                  logic [7:0] cr, logic second);
      rsp_item_type pix;
      int           y;
      int           u;
      int           v;
      y = int'(luma) * 256;
      u = int'(cb) - ChromaBias;
      v = int'(cr) - ChromaBias;
      pix.red       = clamp_channel(y + RedFromV * v);
      pix.green     = clamp_channel(y - GreenFromU * u - GreenFromV * v);
      pix.blue      = clamp_channel(y + BlueFromU * u);
      pix.pair_last = second;
      return pix;
   endfunction

   task automatic check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         byte_phase = PH_Y0;
         luma_first = '0;
         chroma_blue = '0;
         luma_second = '0;
         expected_pixels.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            // start flag drops any partial group
            if (req_data.group_start) begin
               byte_phase = PH_Y0;
            end
            case (byte_phase)
               PH_Y0: begin
                  luma_first = req_data.data_byte;
                  byte_phase = PH_U;
               end
               PH_U: begin
                  chroma_blue = req_data.data_byte;
                  byte_phase = PH_Y1;
               end
               PH_Y1: begin
                  luma_second = req_data.data_byte;
                  byte_phase = PH_V;
               end
               default: begin
                  expected_pixels.push_back(
                     convert_pixel(luma_first, chroma_blue, req_data.data_byte, 1'b0));
                  expected_pixels.push_back(
                     convert_pixel(luma_second, chroma_blue, req_data.data_byte, 1'b1));
                  byte_phase = PH_Y0;
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel: red %0d green %0d blue %0d pair_last %0d",
                      rsp_data.red, rsp_data.green, rsp_data.blue, rsp_data.pair_last);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("red", want.red, rsp_data.red);
               check_field("green", want.green, rsp_data.green);
               check_field("blue", want.blue, rsp_data.blue);
               check_field("pair_last", want.pair_last, rsp_data.pair_last);
            end
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

// ----- tb/yuyv_to_rgb_converter_core_test.sv -----
module yuyv_to_rgb_converter_core_test;

   import yuyv2rgb_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int SettleSpan  = 16;
   localparam int PhaseBytes  = 480;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;

   int mismatch_count;
   int pending_count;
   int cycle_count;
   int send_idle_pct;
   int recv_stall_pct;
   int bytes_sent;
   bit stream_aligned;

   yuyv_to_rgb_converter_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rgb_pair_compare i_compare (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // req_stall is read at the falling edge, where it is settled
   task automatic send_byte(logic [7:0] value, logic start);
      logic stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: value, group_start: start};
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 4) return 8'h00;
      if (r < 8) return 8'hff;
      if (r < 11) return 8'h80;
      if (r < 13) return 8'h10;
      if (r < 15) return 8'heb;
      return 8'($urandom_range(255));
   endfunction

   // mostly whole groups; some truncated groups and stray bytes
   task automatic send_random(int count);
      int stop;
      int r;
      int n;
      stop = bytes_sent + count;
      while (bytes_sent < stop) begin
         r = $urandom_range(99);
         if (r < 82) begin
            send_byte(pick_byte(), stream_aligned ? 1'($urandom_range(1)) : 1'b1);
            repeat (3) send_byte(pick_byte(), 1'b0);
            stream_aligned = 1'b1;
         end else if (r < 94) begin
            n = $urandom_range(1, 3);
            send_byte(pick_byte(), 1'b1);
            repeat (n - 1) send_byte(pick_byte(), 1'b0);
            stream_aligned = 1'b0;
         end else begin
            send_byte(pick_byte(), 1'($urandom_range(1)));
            stream_aligned = 1'b0;
         end
      end
   endtask

   task automatic run_phase(int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      send_random(PhaseBytes / 2);
      drain_results();
      send_random(PhaseBytes / 2);
      drain_results();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      cycle_count    = 0;
      bytes_sent     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      stream_aligned = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero group: both chroma at the low end
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      // all-ones group, aligned without a start flag
      repeat (4) send_byte(8'hff, 1'b0);
      // saturating blue, starved red
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      // realign on the Y1 byte twice, then on V
      send_byte(8'haa, 1'b1);
      send_byte(8'h55, 1'b0);
      send_byte(8'h11, 1'b1);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b1);
      send_byte(8'h44, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h66, 1'b1);
      // neutral chroma completes the realigned group
      send_byte(8'h80, 1'b0);
      send_byte(8'heb, 1'b0);
      send_byte(8'h80, 1'b0);
      drain_results();

      run_phase(31, 78);
      run_phase(78, 31);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random(PhaseBytes);
      drain_results();
      repeat (SettleSpan) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
